FILE: sv/pws_pkg.sv
// ---------------------------------------------------------------------------
// pws_pkg
// Shared constants, operation codes and types of the window scorer.
// ---------------------------------------------------------------------------
`default_nettype none

package pws_pkg;

    // matrix size
    localparam int MAX_LEN  = 32;
    localparam int ALPHABET = 4;
    localparam int CHARS    = 256;

    // field widths
    localparam int OP_W    = 2;
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int LET_W   = $clog2(ALPHABET);
    localparam int SCORE_W = 16;
    localparam int CHAR_W  = 8;
    localparam int SUM_W   = 21;
    localparam int LEN_W   = 6;

    // config port
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN = 1'b0;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_SCORE = 2'd0,
        OP_LOAD_MAP   = 2'd1,
        OP_PUSH       = 2'd2,
        OP_NEW_SEQ    = 2'd3
    } t_op;

    // control word broadcast along the cell row
    typedef struct packed {
        logic                      push;
        logic                      clear;
        logic                      load;
        logic [LET_W-1:0]          load_letter;
        logic signed [SCORE_W-1:0] load_value;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: sv/pws_if.sv
// ---------------------------------------------------------------------------
// pws_if
// Valid/ready channels of the window scorer: input words and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface pws_in_if import pws_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [POS_W-1:0]          position;
    logic [LET_W-1:0]          letter;
    logic signed [SCORE_W-1:0] score_value;
    logic [CHAR_W-1:0]         char_code;
    logic                      char_valid;

    modport source (output valid, output operation, output position, output letter,
                    output score_value, output char_code, output char_valid,
                    input ready);
    modport sink   (input valid, input operation, input position, input letter,
                    input score_value, input char_code, input char_valid,
                    output ready);
endinterface

interface pws_res_if import pws_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] window_score;
    logic                    bad_char;

    modport source (output valid, output window_score, output bad_char, input ready);
    modport sink   (input valid, input window_score, input bad_char, output ready);
endinterface

`default_nettype wire

FILE: sv/pwm_window_scorer.sv
// ---------------------------------------------------------------------------
// pwm_window_scorer
// Position weight matrix scan over a character stream, one cell per position.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake       | word
//  i_in     | in  | valid/ready     | operation, position, letter, score_value,
//           |     |                 | char_code, char_valid
//  o_res    | out | valid/ready     | window_score, bad_char
//  apb      | in  | psel/penable    | motif_length at byte address 0
//
// One word per cycle. Stage one looks up the character map (registered read);
// stage two updates the whole cell row at once, every cell adding its score to
// its neighbor's sum. An accepted word is held in stage one, then its result
// goes to the output register. Reset clears map valid flops and sums. A full
// output register that is not taken holds stage two and then the input.
// ---------------------------------------------------------------------------
`default_nettype none

module pwm_window_scorer import pws_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    pws_in_if.sink                 i_in,
    pws_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    // config
    logic [LEN_W-1:0]     r_len;
    logic                 w_cfg_wr;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic                 w_len_wr;

    // stage one
    logic                      r_s1_valid;
    t_op                       r_s1_op;
    logic [POS_W-1:0]          r_s1_pos;
    logic [LET_W-1:0]          r_s1_letter;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic [LET_W-1:0]          w_map_letter;
    logic                      w_map_valid;

    // stage two and output
    logic                    w_accept;
    logic                    w_adv;
    logic                    w_fire;
    logic [LEN_W-1:0]        r_count;
    logic [LEN_W-1:0]        n_count;
    logic [LEN_W-1:0]        w_n_eff;
    logic [POS_W-1:0]        w_n_idx;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [SUM_W-1:0] r_out_score;
    logic signed [SUM_W-1:0] n_out_score;
    logic                    r_out_bad;
    logic                    n_out_bad;
    logic                    w_push;
    logic                    w_clear;
    logic                    w_load;
    logic                    w_produce;

    logic signed [SUM_W-1:0] w_sum      [MAX_LEN];
    logic signed [SUM_W-1:0] w_sum_next [MAX_LEN];

    // ---- configuration port ----
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[CFG_AW-1:2];
    assign w_len_wr  = w_cfg_wr && (w_cfg_idx == REG_MOTIF_LEN);
    assign prdata    = (w_cfg_idx == REG_MOTIF_LEN) ? CFG_DW'(r_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (w_len_wr) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    // clamp window length to 1..MAX_LEN
    always_comb begin
        if (r_len == '0) begin
            w_n_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_LEN)) begin
            w_n_eff = LEN_W'(MAX_LEN);
        end else begin
            w_n_eff = r_len;
        end
    end
    assign w_n_idx = POS_W'(w_n_eff - LEN_W'(1));

    // ---- handshake ----
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_in.ready  = !r_s1_valid || w_adv;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_fire      = r_s1_valid && w_adv;

    // ---- stage one: map lookup and map writes ----
    pws_cmap u_cmap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (w_accept && (t_op'(i_in.operation) == OP_LOAD_MAP)),
        .i_wr_code   (i_in.char_code),
        .i_wr_letter (i_in.letter),
        .i_wr_valid  (i_in.char_valid),
        .i_re        (w_accept && (t_op'(i_in.operation) == OP_PUSH)),
        .i_rd_code   (i_in.char_code),
        .o_rd_letter (w_map_letter),
        .o_rd_valid  (w_map_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op     <= t_op'(i_in.operation);
            r_s1_pos    <= i_in.position;
            r_s1_letter <= i_in.letter;
            r_s1_score  <= i_in.score_value;
        end
    end

    // ---- stage two: decode into row controls ----
    always_comb begin
        w_push    = 1'b0;
        w_clear   = w_len_wr;
        w_load    = 1'b0;
        w_produce = 1'b0;
        n_count   = r_count;
        if (w_fire) begin
            unique case (r_s1_op)
                OP_LOAD_SCORE: w_load = 1'b1;
                OP_LOAD_MAP:   ;
                OP_NEW_SEQ:    w_clear = 1'b1;
                OP_PUSH: begin
                    w_produce = 1'b1;
                    if (!w_map_valid) begin
                        w_clear = 1'b1;
                    end else begin
                        w_push = 1'b1;
                        if (r_count < w_n_eff) begin
                            n_count = r_count + LEN_W'(1);
                        end
                        w_produce = (n_count == w_n_eff);
                    end
                end
                default: ;
            endcase
        end
        if (w_clear) begin
            n_count = '0;
        end
    end

    // ---- cell row ----
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        t_cell_ctl               w_ctl;
        logic signed [SUM_W-1:0] w_prev;

        assign w_ctl.push        = w_push;
        assign w_ctl.clear       = w_clear;
        assign w_ctl.load        = w_load && (r_s1_pos == POS_W'(k));
        assign w_ctl.load_letter = r_s1_letter;
        assign w_ctl.load_value  = r_s1_score;

        if (k == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_link
            assign w_prev = w_sum[k-1];
        end

        pws_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_letter   (w_map_letter),
            .i_prev_sum (w_prev),
            .o_sum      (w_sum[k]),
            .o_sum_next (w_sum_next[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ---- output register ----
    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_score = r_out_score;
        n_out_bad   = r_out_bad;
        if (w_produce) begin
            n_out_valid = 1'b1;
            n_out_bad   = !w_map_valid;
            n_out_score = w_map_valid ? w_sum_next[w_n_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_score <= n_out_score;
        r_out_bad   <= n_out_bad;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.window_score = r_out_score;
    assign o_res.bad_char     = r_out_bad;

endmodule

`default_nettype wire

FILE: sv/pws_cmap.sv
// ---------------------------------------------------------------------------
// pws_cmap
// Byte-to-letter map: letter memory with per-entry valid flops, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pws_cmap import pws_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [CHAR_W-1:0] i_wr_code,
    input  wire logic [LET_W-1:0]  i_wr_letter,
    input  wire logic              i_wr_valid,
    input  wire logic              i_re,
    input  wire logic [CHAR_W-1:0] i_rd_code,
    output logic      [LET_W-1:0]  o_rd_letter,
    output logic                   o_rd_valid
);

    logic [LET_W-1:0] r_letter_mem [CHARS];
    logic [CHARS-1:0] r_valid;
    logic [LET_W-1:0] r_rd_letter;
    logic             r_rd_valid;

    // valid marks, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wr_code] <= i_wr_valid;
        end
    end

    // letter memory; letter of an unmapped entry is never used
    always_ff @(posedge i_clk) begin
        if (i_we && i_wr_valid) begin
            r_letter_mem[i_wr_code] <= i_wr_letter;
        end
    end

    // registered lookup
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_letter <= r_letter_mem[i_rd_code];
            r_rd_valid  <= r_valid[i_rd_code];
        end
    end

    assign o_rd_letter = r_rd_letter;
    assign o_rd_valid  = r_rd_valid;

endmodule

`default_nettype wire

FILE: sv/pws_cell.sv
// ---------------------------------------------------------------------------
// pws_cell
// One matrix position: its score column and the partial sum of one open window.
// ---------------------------------------------------------------------------
`default_nettype none

module pws_cell import pws_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic [LET_W-1:0]        i_letter,
    input  wire logic signed [SUM_W-1:0] i_prev_sum,
    output logic signed [SUM_W-1:0]      o_sum,
    output logic signed [SUM_W-1:0]      o_sum_next
);

    logic signed [SCORE_W-1:0] r_col [ALPHABET];
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W:0]     w_wide;

    // score column load
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_col[i_ctl.load_letter] <= i_ctl.load_value;
        end
    end

    // neighbor sum plus this position's score, saturated
    always_comb begin
        w_wide = {i_prev_sum[SUM_W-1], i_prev_sum} + (SUM_W+1)'(r_col[i_letter]);
        if (w_wide[SUM_W] != w_wide[SUM_W-1]) begin
            o_sum_next = w_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            o_sum_next = w_wide[SUM_W-1:0];
        end
    end

    // partial sum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.push) begin
            r_sum <= o_sum_next;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

FILE: sv/pws_checker.sv
// ---------------------------------------------------------------------------
// pws_checker
// Port-level checks of the window scorer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pws_checker import pws_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_ready,
    input wire logic                    i_res_valid,
    input wire logic                    i_res_ready,
    input wire logic signed [SUM_W-1:0] i_res_score,
    input wire logic                    i_res_bad,
    input wire logic                    i_psel,
    input wire logic                    i_penable,
    input wire logic                    i_pwrite,
    input wire logic [CFG_AW-1:0]       i_paddr,
    input wire logic [CFG_DW-1:0]       i_pwdata,
    input wire logic [CFG_DW-1:0]       i_prdata
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // input only stalls behind a full, blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_res_valid && !i_res_ready))
        else $error("input stalled without output back-pressure");

    // a bad character carries a zero score
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_bad) |-> (i_res_score == '0))
        else $error("bad character word with nonzero score");

    // blocked result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_score) && $stable(i_res_bad)))
        else $error("blocked result changed");

    // length register reads back what was written
    a_len_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_psel && i_penable && i_pwrite && (i_paddr[CFG_AW-1:2] == REG_MOTIF_LEN)) |=>
            ((i_paddr[CFG_AW-1:2] != REG_MOTIF_LEN) ||
             (i_prdata == CFG_DW'($past(i_pwdata[LEN_W-1:0])))))
        else $error("motif length readback mismatch");

endmodule

bind pwm_window_scorer pws_checker u_pws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_score (o_res.window_score),
    .i_res_bad   (o_res.bad_char),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

`default_nettype wire

FILE: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for pwm_window_scorer. A directed table loads a small
// matrix and character map and checks hand-computed scores at window length
// one. Extreme sums at the longest window follow, then random phases at many
// window lengths. Every accepted word runs through a local model of the
// scanner; result words are checked in order against its predictions.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pws_pkg::*;

    localparam int     DIR_N          = 23;
    localparam int     PHASES         = 10;
    localparam int     PHASE_WORDS    = 140;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     HOLD_CYCLES    = 80;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam longint SUM_HI         = 2**(SUM_W-1) - 1;
    localparam longint SUM_LO         = -(2**(SUM_W-1));

    typedef struct packed {
        t_op                       op;
        logic [POS_W-1:0]          pos;
        logic [LET_W-1:0]          ltr;
        logic signed [SCORE_W-1:0] sval;
        logic [CHAR_W-1:0]         chr;
        logic                      cv;
    } t_scan_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] score;
        logic                    bad;
    } t_res_word;

    typedef struct packed {
        t_scan_word w;
        logic       typed;
        t_res_word  want;
    } t_dir_row;

    typedef enum int {RX_FREE, RX_PATTERN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    localparam t_res_word NO_RES  = '{21'sd0, 1'b0};
    localparam t_res_word BAD_RES = '{21'sd0, 1'b1};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    pws_in_if  in_if ();
    pws_res_if res_if ();

    pwm_window_scorer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scanner model state
    logic signed [SCORE_W-1:0] pwm_tbl [MAX_LEN][ALPHABET];
    logic                      map_ok  [CHARS];
    logic [LET_W-1:0]          map_ltr [CHARS];
    logic signed [SUM_W-1:0]   open_sums [MAX_LEN];
    int                        got_chars;
    logic [LEN_W-1:0]          motif_len;

    t_res_word pending_scores [$];

    // bench bookkeeping
    int words_in, results_seen, bad_seen, windows_seen, fails, cfg_writes;
    int burst_left, holds_asked, holds_done;
    bit steady;

    // directed words: window length one, scores at position 0 and one at position 31
    t_dir_row dir_rows [DIR_N] = '{
        '{'{OP_PUSH,       5'd9,  2'd3, 16'sh1357, 8'h41, 1'b1}, 1'b1, BAD_RES},
        '{'{OP_LOAD_MAP,   5'd4,  2'd2, 16'sh0F0F, 8'h41, 1'b0}, 1'b0, NO_RES},
        '{'{OP_LOAD_SCORE, 5'd0,  2'd0, 16'sh7FFF, 8'hAA, 1'b0}, 1'b0, NO_RES},
        '{'{OP_LOAD_SCORE, 5'd0,  2'd1, 16'sh8000, 8'h55, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_SCORE, 5'd0,  2'd2, 16'sh0100, 8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{OP_LOAD_SCORE, 5'd0,  2'd3, 16'shFFFF, 8'hFF, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_SCORE, 5'd31, 2'd3, 16'sh5A5A, 8'h12, 1'b0}, 1'b0, NO_RES},
        '{'{OP_LOAD_MAP,   5'd31, 2'd0, 16'shFFFF, 8'h00, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_MAP,   5'd0,  2'd1, 16'sh0000, 8'hFF, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_MAP,   5'd17, 2'd2, 16'sh2468, 8'h41, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_MAP,   5'd8,  2'd3, 16'sh8001, 8'h80, 1'b1}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd31, 2'd3, 16'shFFFF, 8'h00, 1'b0}, 1'b1, '{21'sd32767, 1'b0}},
        '{'{OP_PUSH,       5'd0,  2'd0, 16'sh0000, 8'hFF, 1'b1}, 1'b1, '{-21'sd32768, 1'b0}},
        '{'{OP_PUSH,       5'd21, 2'd1, 16'sh7654, 8'h41, 1'b0}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd10, 2'd2, 16'sh89AB, 8'h80, 1'b1}, 1'b0, NO_RES},
        '{'{OP_LOAD_MAP,   5'd3,  2'd3, 16'sh4321, 8'h80, 1'b0}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd5,  2'd0, 16'sh1111, 8'h80, 1'b0}, 1'b1, BAD_RES},
        '{'{OP_LOAD_MAP,   5'd30, 2'd0, 16'sh7FFF, 8'h7F, 1'b1}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd1,  2'd1, 16'sh8000, 8'h7F, 1'b1}, 1'b1, '{21'sd32767, 1'b0}},
        '{'{OP_NEW_SEQ,    5'd15, 2'd2, 16'shC3C3, 8'hC3, 1'b1}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd16, 2'd3, 16'sh3C3C, 8'hFF, 1'b0}, 1'b1, '{-21'sd32768, 1'b0}},
        '{'{OP_LOAD_MAP,   5'd2,  2'd2, 16'sh0001, 8'hFF, 1'b1}, 1'b0, NO_RES},
        '{'{OP_PUSH,       5'd29, 2'd0, 16'shFFFE, 8'hFF, 1'b1}, 1'b0, NO_RES}
    };

    function automatic logic signed [SUM_W-1:0] clip_sum(input longint v);
        if (v > SUM_HI) return SUM_HI[SUM_W-1:0];
        if (v < SUM_LO) return SUM_LO[SUM_W-1:0];
        return v[SUM_W-1:0];
    endfunction

    function automatic int window_len();
        if (motif_len == 0) return 1;
        if (motif_len > MAX_LEN) return MAX_LEN;
        return int'(motif_len);
    endfunction

    function automatic void restart_windows();
        foreach (open_sums[k]) open_sums[k] = '0;
        got_chars = 0;
    endfunction

    // Advance the model by one word; has_res tells if a result word follows.
    function automatic void scan_step(input t_scan_word w, output bit has_res,
                                      output t_res_word r);
        int               n;
        logic [LET_W-1:0] c;
        has_res = 1'b0;
        r       = NO_RES;
        case (w.op)
            OP_LOAD_SCORE: pwm_tbl[w.pos][w.ltr] = w.sval;
            OP_LOAD_MAP: begin
                map_ok[w.chr]  = w.cv;
                map_ltr[w.chr] = w.cv ? w.ltr : '0;
            end
            OP_NEW_SEQ: restart_windows();
            default: begin
                if (!map_ok[w.chr]) begin
                    restart_windows();
                    has_res = 1'b1;
                    r       = BAD_RES;
                end else begin
                    c = map_ltr[w.chr];
                    n = window_len();
                    // each open window moves one position along the matrix
                    for (int k = n - 1; k >= 1; k--)
                        open_sums[k] = clip_sum(longint'(open_sums[k-1]) +
                                                longint'(pwm_tbl[k][c]));
                    open_sums[0] = clip_sum(longint'(pwm_tbl[0][c]));
                    if (got_chars < n) got_chars++;
                    if (got_chars == n) begin
                        has_res = 1'b1;
                        r.score = open_sums[n-1];
                    end
                end
            end
        endcase
    endfunction

    function automatic t_scan_word rand_word();
        t_scan_word w;
        w.op   = t_op'($urandom_range(0, 3));
        w.pos  = POS_W'($urandom);
        w.ltr  = LET_W'($urandom);
        w.sval = SCORE_W'($urandom);
        w.chr  = CHAR_W'($urandom);
        w.cv   = 1'($urandom);
        return w;
    endfunction

    // Random score with the extremes well represented.
    function automatic logic signed [SCORE_W-1:0] rand_score();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_mapped_char();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom);
        for (int i = 0; i < 64 && !map_ok[c]; i++) c = CHAR_W'($urandom);
        return c;
    endfunction

    // Offer one word, wait for it to be taken, then predict. Bursts and gaps
    // of the sender are handled here.
    task automatic offer(input t_scan_word w, input bit typed, input t_res_word typed_res);
        bit        has_res;
        t_res_word r;
        int        gap;
        in_if.valid       <= 1'b1;
        in_if.operation   <= w.op;
        in_if.position    <= w.pos;
        in_if.letter      <= w.ltr;
        in_if.score_value <= w.sval;
        in_if.char_code   <= w.chr;
        in_if.char_valid  <= w.cv;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        words_in++;
        scan_step(w, has_res, r);
        if (typed)        pending_scores = {pending_scores, typed_res};
        else if (has_res) pending_scores = {pending_scores, r};
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic offer_word(input t_scan_word w);
        offer(w, 1'b0, NO_RES);
    endtask

    // Stop sending and let every outstanding word work its way out.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_motif_len(input logic [LEN_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({REG_MOTIF_LEN, 2'b00});
        pwdata  <= ($urandom & ~32'h3F) | CFG_DW'(len);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        motif_len = len;
        restart_windows();
        cfg_writes++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res_word want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_seen++;
            if (res_if.bad_char === 1'b1) bad_seen++;
            else windows_seen++;
            if (pending_scores.size() == 0) begin
                $display("%0t: result word with nothing expected: window_score %0d bad_char %b",
                         $time, res_if.window_score, res_if.bad_char);
                fails++;
            end else begin
                want = pending_scores.pop_front();
                if (res_if.window_score !== want.score) begin
                    $display("%0t: window_score expected %0d, got %0d",
                             $time, want.score, res_if.window_score);
                    fails++;
                end
                if (res_if.bad_char !== want.bad) begin
                    $display("%0t: bad_char expected %b, got %b",
                             $time, want.bad, res_if.bad_char);
                    fails++;
                end
            end
        end
    end

    // result side stalls: random ready modes; long hold on request
    t_rx_mode    rx_mode = RX_FREE;
    logic [31:0] rx_pat  = '1;
    int          rx_cyc, hold_left;

    always @(posedge i_clk) begin
        rx_cyc++;
        if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else begin
            if (rx_cyc % 48 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_pat  = $urandom;
            end
            case (rx_mode)
                RX_FREE:    res_if.ready <= 1'b1;
                RX_PATTERN: res_if.ready <= rx_pat[rx_cyc % 32];
                RX_RANDOM:  res_if.ready <= ($urandom_range(0, 3) != 0);
                default:    res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: too long without any word moving on either channel
    int quiet;

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet, pending_scores.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [LEN_W-1:0] lens [PHASES];
        t_scan_word       w;
        int               r, noise;

        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_if.valid       <= 1'b0;
        in_if.operation   <= OP_NEW_SEQ;
        in_if.position    <= '0;
        in_if.letter      <= '0;
        in_if.score_value <= '0;
        in_if.char_code   <= '0;
        in_if.char_valid  <= 1'b0;

        foreach (map_ok[i]) begin
            map_ok[i]  = 1'b0;
            map_ltr[i] = '0;
        end
        motif_len = LEN_W'(1);
        restart_windows();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[i]) offer(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // longest window: all-max and all-min scores give the largest and smallest window sums
        write_motif_len(LEN_W'(MAX_LEN));
        for (int p = 0; p < MAX_LEN; p++) begin
            offer_word('{OP_LOAD_SCORE, POS_W'(p), 2'd0, 16'sh7FFF, 8'h3C, 1'b1});
            offer_word('{OP_LOAD_SCORE, POS_W'(p), 2'd1, 16'sh8000, 8'hC3, 1'b0});
        end
        offer_word('{OP_LOAD_MAP, 5'd0, 2'd1, 16'sh0000, 8'hFF, 1'b1});
        repeat (MAX_LEN + 4) offer_word('{OP_PUSH, 5'd0, 2'd0, 16'sh0000, 8'h00, 1'b1});
        repeat (MAX_LEN + 4) offer_word('{OP_PUSH, 5'd0, 2'd0, 16'sh0000, 8'hFF, 1'b1});

        // fill the rest of the matrix and widen the character map
        for (int p = 0; p < MAX_LEN; p++)
            for (int l = 2; l < ALPHABET; l++) begin
                w      = rand_word();
                w.op   = OP_LOAD_SCORE;
                w.pos  = POS_W'(p);
                w.ltr  = LET_W'(l);
                w.sval = rand_score();
                offer_word(w);
            end
        repeat (40) begin
            w    = rand_word();
            w.op = OP_LOAD_MAP;
            w.cv = 1'b1;
            offer_word(w);
        end

        // random phases, one window length each
        lens = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd3, 6'd31, 6'd32, 6'd16, 6'd0, 6'd7};
        lens[8] = LEN_W'($urandom_range(4, 30));
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_motif_len(lens[ph]);
            steady = (ph == 3) || ($urandom_range(0, 3) == 0);
            // short windows with a back-to-back sender: block fills under a hold
            if (ph == 3) holds_asked++;
            noise = (window_len() >= 16) ? 1 : 3;
            repeat (PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                w = rand_word();
                if (r < noise) begin
                    w.op = OP_NEW_SEQ;
                end else if (r < 2 * noise) begin
                    w.op = OP_PUSH;
                end else if (r < 2 * noise + 3) begin
                    w.op   = OP_LOAD_SCORE;
                    w.sval = rand_score();
                end else if (r < 2 * noise + 6) begin
                    w.op = OP_LOAD_MAP;
                    w.cv = 1'b1;
                end else if (r < 2 * noise + 7) begin
                    w.op = OP_LOAD_MAP;
                    w.cv = 1'b0;
                end else begin
                    w.op  = OP_PUSH;
                    w.chr = pick_mapped_char();
                end
                offer_word(w);
            end
        end
        drain();

        $display("%0d words in, %0d length writes; %0d results: %0d full windows, %0d bad chars",
                 words_in, cfg_writes, results_seen, windows_seen, bad_seen);
        $display("covered window lengths 1 to %0d with clamped settings and stalls; %0d mismatches",
                 MAX_LEN, fails);
        if (fails == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/pws_pkg.sv
sv/pws_if.sv
sv/pws_cmap.sv
sv/pws_cell.sv
sv/pwm_window_scorer.sv
sv/pws_checker.sv
dv/tb_top.sv
